### hw/rtl/eau_pkg.sv
// eau_pkg: shared types, codes and helper functions of the effective address unit
// no dependencies; imported by eau_calc and effective_address_unit
package eau_pkg;

   // addressing mode field codes
   localparam logic [2:0] MODE_DREG     = 3'd0;
   localparam logic [2:0] MODE_AREG     = 3'd1;
   localparam logic [2:0] MODE_IND      = 3'd2;
   localparam logic [2:0] MODE_POSTINC  = 3'd3;
   localparam logic [2:0] MODE_PREDEC   = 3'd4;
   localparam logic [2:0] MODE_DISP     = 3'd5;
   localparam logic [2:0] MODE_INDEX    = 3'd6;
   localparam logic [2:0] MODE_SPECIAL  = 3'd7;

   // register field codes under the special mode
   localparam logic [2:0] SUB_ABS_W     = 3'd0;
   localparam logic [2:0] SUB_ABS_L     = 3'd1;
   localparam logic [2:0] SUB_PC_DISP   = 3'd2;
   localparam logic [2:0] SUB_PC_INDEX  = 3'd3;
   localparam logic [2:0] SUB_IMM       = 3'd4;

   // operand size codes
   localparam logic [1:0] SIZE_BYTE     = 2'd0;
   localparam logic [1:0] SIZE_WORD     = 2'd1;

   localparam logic [2:0] STACK_REG     = 3'd7;
   localparam logic [31:0] ADDR24_MASK  = 32'h00FF_FFFF;

   // calculation cycles for byte/word; long adds LONG_EXTRA
   localparam logic [4:0] CYC_IND       = 5'd4;
   localparam logic [4:0] CYC_PREDEC    = 5'd6;
   localparam logic [4:0] CYC_DISP      = 5'd8;
   localparam logic [4:0] CYC_INDEX     = 5'd10;
   localparam logic [4:0] CYC_ABS_L     = 5'd12;
   localparam logic [4:0] CYC_IMM       = 5'd4;
   localparam logic [4:0] LONG_EXTRA    = 5'd4;

   typedef enum logic [1:0] {
      KIND_DREG    = 2'd0,
      KIND_AREG    = 2'd1,
      KIND_MEM     = 2'd2,
      KIND_UNSUPP  = 2'd3
   } kind_type;

   // operand description as used by the calculation
   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  reg_num;
      logic [1:0]  op_size;
      logic [31:0] base_value;
      logic [31:0] index_value;
      logic [15:0] ext_first;
      logic [15:0] ext_second;
      logic [31:0] ext_addr;
   } operand_type;

   typedef struct packed {
      logic [4:0]  calc_cycles;
      logic [1:0]  ext_used;
      logic        base_write;
      logic [31:0] new_base;
      logic [31:0] direct_value;
      logic [31:0] eff_addr;
      kind_type    kind;
   } result_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sext8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   // brief extension word: bit 11 picks a long index, low byte is displacement
   function automatic logic [31:0] brief_offset(input logic [15:0] ext,
                                                input logic [31:0] idx);
      logic [31:0] x;
      x = ext[11] ? idx : sext16(idx[15:0]);
      return sext8(ext[7:0]) + x;
   endfunction

   // byte step on the stack pointer keeps it word aligned
   function automatic logic [31:0] step_bytes(input logic [1:0] size,
                                              input logic [2:0] rnum);
      logic [31:0] s;
      case (size)
         SIZE_BYTE: s = (rnum == STACK_REG) ? 32'd2 : 32'd1;
         SIZE_WORD: s = 32'd2;
         default:   s = 32'd4;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] size_mask(input logic [1:0] size);
      logic [31:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_00FF;
         SIZE_WORD: m = 32'h0000_FFFF;
         default:   m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

### hw/rtl/effective_address_unit.sv
// effective_address_unit: top level, input register, address calculation, result register
// depends on eau_pkg and eau_calc
//
//  channel | direction | word                                 | bits
//  --------+-----------+--------------------------------------+--------
//  req_    | in        | operand mode, regs, ext              | 168
//  rsp_    | out       | address, writeback; kind on tuser    | 104 + 2
//
// one word accepted per cycle while rsp_ does not stall; the input register takes it at the
// accepting edge, the result register takes it when the result stage loads and then offers
// it on rsp_; the combinational calculation in eau_calc sits between the two registers
// reset clears only the two valid flags; payload registers are left as they are
// a stalled rsp_ holds the result register, the input register then fills and
// req_tready drops; both stages move together as soon as rsp_tready returns
module effective_address_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[2:0], reg_num[5:3], op_size[7:6], base_value[39:8],
   // index_value[71:40], ext_first[87:72], ext_second[103:88],
   // instr_addr[135:104], ext_addr[167:136]
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // eff_addr[31:0], direct_value[63:32], new_base[95:64],
   // base_write[96], ext_used[98:97], calc_cycles[103:99]
   output logic [103:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]   rsp_tuser
);
   import eau_pkg::*;

   // input stage
   logic        in_valid_ff, in_valid_in;
   operand_type op_ff, op_in;

   // result stage
   logic        out_valid_ff, out_valid_in;
   result_type  res_ff, res_in;

   logic        out_load;
   logic        in_load;

   // result register takes a new word when empty or being drained
   assign out_load   = !out_valid_ff || rsp_tready;
   // input register moves on when empty or when its word goes to the result stage
   assign in_load    = !in_valid_ff || out_load;
   assign req_tready = in_load;

   // unpack the request word; the opcode address plays no part in the sums
   always_comb begin
      op_in.mode        = req_tdata[2:0];
      op_in.reg_num     = req_tdata[5:3];
      op_in.op_size     = req_tdata[7:6];
      op_in.base_value  = req_tdata[39:8];
      op_in.index_value = req_tdata[71:40];
      op_in.ext_first   = req_tdata[87:72];
      op_in.ext_second  = req_tdata[103:88];
      op_in.ext_addr    = req_tdata[167:136];
   end

   assign in_valid_in  = in_load ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         op_ff <= op_in;
      end
      if (out_load && in_valid_ff) begin
         res_ff <= res_in;
      end
   end

   eau_calc u_calc (
      .op  (op_ff),
      .res (res_in)
   );

   // kind sits in the two lowest bits of the result struct
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = res_ff[105:2];
   assign rsp_tuser  = res_ff.kind;

endmodule

### hw/rtl/eau_calc.sv
// eau_calc: combinational effective address, writeback and timing for one operand
// depends on eau_pkg
module eau_calc (
   input  eau_pkg::operand_type op,
   output eau_pkg::result_type  res
);
   import eau_pkg::*;

   logic        is_long;
   logic [31:0] step;
   logic [31:0] dec_base;
   logic [4:0]  cyc;

   assign is_long  = op.op_size[1];
   assign step     = step_bytes(op.op_size, op.reg_num);
   assign dec_base = op.base_value - step;

   always_comb begin
      res              = '0;
      res.kind         = KIND_MEM;
      res.new_base     = op.base_value;
      cyc              = '0;
      case (op.mode)
         MODE_DREG: begin
            res.kind         = KIND_DREG;
            res.direct_value = op.base_value & size_mask(op.op_size);
         end
         MODE_AREG: begin
            res.kind         = KIND_AREG;
            res.direct_value = op.base_value & size_mask(op.op_size);
         end
         MODE_IND: begin
            res.eff_addr = op.base_value & ADDR24_MASK;
            cyc          = CYC_IND;
         end
         MODE_POSTINC: begin
            res.eff_addr   = op.base_value & ADDR24_MASK;
            res.new_base   = op.base_value + step;
            res.base_write = 1'b1;
            cyc            = CYC_IND;
         end
         MODE_PREDEC: begin
            res.new_base   = dec_base;
            res.eff_addr   = dec_base & ADDR24_MASK;
            res.base_write = 1'b1;
            cyc            = CYC_PREDEC;
         end
         MODE_DISP: begin
            res.eff_addr = op.base_value + sext16(op.ext_first);
            res.ext_used = 2'd1;
            cyc          = CYC_DISP;
         end
         MODE_INDEX: begin
            res.eff_addr = op.base_value + brief_offset(op.ext_first, op.index_value);
            res.ext_used = 2'd1;
            cyc          = CYC_INDEX;
         end
         default: begin
            case (op.reg_num)
               SUB_ABS_W: begin
                  res.eff_addr = sext16(op.ext_first);
                  res.ext_used = 2'd1;
                  cyc          = CYC_DISP;
               end
               SUB_ABS_L: begin
                  // high word comes first
                  res.eff_addr = {op.ext_first, op.ext_second};
                  res.ext_used = 2'd2;
                  cyc          = CYC_ABS_L;
               end
               SUB_PC_DISP: begin
                  res.eff_addr = op.ext_addr + sext16(op.ext_first);
                  res.ext_used = 2'd1;
                  cyc          = CYC_DISP;
               end
               SUB_PC_INDEX: begin
                  res.eff_addr = op.ext_addr + brief_offset(op.ext_first, op.index_value);
                  res.ext_used = 2'd1;
                  cyc          = CYC_INDEX;
               end
               SUB_IMM: begin
                  res.eff_addr = op.ext_addr;
                  res.ext_used = is_long ? 2'd2 : 2'd1;
                  cyc          = CYC_IMM;
               end
               default: begin
                  res.kind = KIND_UNSUPP;
               end
            endcase
         end
      endcase
      res.calc_cycles = (cyc != '0 && is_long) ? cyc + LONG_EXTRA : cyc;
   end

endmodule
